FILE: design/gsfr_pkg.sv
// Shared types and constants for the gas sensor frame receiver.
package gsfr_pkg;

  localparam logic [7:0] START_BYTE    = 8'hFF;
  localparam logic [7:0] GAS_TYPE_BYTE = 8'h04;
  localparam logic [7:0] UNIT_BYTE     = 8'h03;
  localparam logic [7:0] ECHO_BYTE     = 8'h86;

  localparam logic [3:0] POS_HUNT     = 4'd0;
  localparam logic [3:0] POS_HEADER   = 4'd1;
  localparam logic [3:0] POS_SECOND   = 4'd2;
  localparam logic [3:0] POS_THIRD    = 4'd3;
  localparam logic [3:0] POS_FOURTH   = 4'd4;
  localparam logic [3:0] POS_FIFTH    = 4'd5;
  localparam logic [3:0] POS_LAST_SUM = 4'd7;
  localparam logic [3:0] POS_CHECKSUM = 4'd8;

  localparam logic MODE_UPLOAD = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_ERROR = 1'b1;

  typedef struct packed {
    logic        status;
    logic [15:0] conc;
  } gsfr_result_t;

endpackage

FILE: design/gas_sensor_frame_receiver.sv
// Top level of the gas sensor frame receiver: channels, mode register, result register.
//
// Bytes from the sensor's serial receiver enter on the rx channel, one request
// per byte, and may arrive in every cycle. The parser hunts for the start byte,
// collects the nine-byte frame and checks header and checksum. On the ninth
// byte, or when hunting runs past HUNT_LIMIT bytes, one result request goes out
// on the res channel: frame_status_o and concentration_tenths_o.
// The result is registered and becomes valid in the cycle after the byte that completes it.
// Throughput: one byte per cycle while rx_ready_o is high; the parser state advances on each accepted byte.
// The result register holds a result while res_ready_i is low; rx_ready_o then
// drops until the result is taken, and rises again in the cycle it is taken.
// The cfg channel writes operating_mode (0 upload, 1 query); it is always ready
// and is meant to be written while the block is idle.
// Reset clears the parser to hunting, the mode to upload and the result
// register to empty.
module gas_sensor_frame_receiver import gsfr_pkg::*; #(
  parameter int HUNT_LIMIT = 27
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_operating_mode_i,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic        frame_status_o,
  output logic [15:0] concentration_tenths_o
);

  logic         mode_q;
  logic         res_valid_q;
  gsfr_result_t res_q;
  logic         rx_fire;
  logic         res_fire;
  gsfr_result_t res_d;

  assign cfg_ready_o = 1'b1;
  assign rx_ready_o  = !res_valid_q || res_ready_i;
  assign rx_fire     = rx_valid_i && rx_ready_o;

  gsfr_parser #(
    .HUNT_LIMIT(HUNT_LIMIT)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (rx_fire),
    .rx_byte_i  (rx_byte_i),
    .mode_i     (mode_q),
    .res_fire_o (res_fire),
    .res_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_UPLOAD;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_operating_mode_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_fire) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_fire) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o            = res_valid_q;
  assign frame_status_o         = res_q.status;
  assign concentration_tenths_o = res_q.conc;

`ifndef NO_ASSERTIONS
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid_o |-> rx_ready_o)
    else $error("rx not ready while result register empty");

  a_error_zero_conc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && frame_status_o |-> concentration_tenths_o == 16'd0)
    else $error("error result carries nonzero concentration");

  a_taken_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_ready_i && !res_fire |=> !res_valid_o)
    else $error("result still valid after it was taken");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_fire |-> !res_valid_o || res_ready_i)
    else $error("new result overwrites a pending one");
`endif

endmodule

FILE: design/gsfr_parser.sv
// Frame parser: hunt, header, checksum and value collection, one byte per step.
module gsfr_parser import gsfr_pkg::*; #(
  parameter int HUNT_LIMIT = 27
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic [7:0]   rx_byte_i,
  input  logic         mode_i,
  output logic         res_fire_o,
  output gsfr_result_t res_o
);

  logic [3:0]  pos_q, pos_d;
  logic [4:0]  hunt_q, hunt_d;
  logic [7:0]  sum_q, sum_d;
  logic        hdr_q, hdr_d;
  logic [15:0] value_q, value_d;

  logic        hunting;
  logic        query;
  logic [5:0]  hunt_next;
  logic        overflow;
  logic [7:0]  expect_sum;

  assign hunting    = (pos_q == POS_HUNT) || (pos_q > POS_CHECKSUM);
  assign query      = (mode_i == MODE_QUERY);
  assign hunt_next  = {1'b0, hunt_q} + 6'd1;
  assign overflow   = hunt_next > 6'(HUNT_LIMIT);
  assign expect_sum = 8'(~sum_q + 8'd1);

  always_comb begin
    pos_d      = pos_q;
    hunt_d     = hunt_q;
    sum_d      = sum_q;
    hdr_d      = hdr_q;
    value_d    = value_q;
    res_fire_o = 1'b0;
    res_o      = '{status: STATUS_ERROR, conc: 16'd0};
    if (hunting) begin
      pos_d = POS_HUNT;
      if (overflow) begin
        hunt_d     = 5'd0;
        res_fire_o = 1'b1;
      end else if (rx_byte_i == START_BYTE) begin
        pos_d   = POS_HEADER;
        hunt_d  = 5'd0;
        sum_d   = 8'd0;
        hdr_d   = 1'b1;
        value_d = 16'd0;
      end else begin
        hunt_d = hunt_next[4:0];
      end
    end else if (pos_q <= POS_LAST_SUM) begin
      sum_d = sum_q + rx_byte_i;
      if (pos_q == POS_HEADER && rx_byte_i != (query ? ECHO_BYTE : GAS_TYPE_BYTE)) begin
        hdr_d = 1'b0;
      end
      if (pos_q == POS_SECOND && !query && rx_byte_i != UNIT_BYTE) begin
        hdr_d = 1'b0;
      end
      if ((query && pos_q == POS_SECOND) || (!query && pos_q == POS_FOURTH)) begin
        value_d[15:8] = rx_byte_i;
      end
      if ((query && pos_q == POS_THIRD) || (!query && pos_q == POS_FIFTH)) begin
        value_d[7:0] = rx_byte_i;
      end
      pos_d = pos_q + 4'd1;
    end else begin
      pos_d      = POS_HUNT;
      hunt_d     = 5'd0;
      res_fire_o = 1'b1;
      if (hdr_q && rx_byte_i == expect_sum) begin
        res_o = '{status: STATUS_OK, conc: value_q};
      end
    end
    if (!step_i) begin
      res_fire_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= POS_HUNT;
      hunt_q  <= 5'd0;
      sum_q   <= 8'd0;
      hdr_q   <= 1'b1;
      value_q <= 16'd0;
    end else if (step_i) begin
      pos_q   <= pos_d;
      hunt_q  <= hunt_d;
      sum_q   <= sum_d;
      hdr_q   <= hdr_d;
      value_q <= value_d;
    end
  end

endmodule
